// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define WSFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

`define WSFD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define WSFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define WSFD_ASSERT(lbl, prop)
`define WSFD_ASSERT_IMPL(lbl, ante, cons)
`define WSFD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- src/wsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);

  localparam logic [31:0] MaxLenReset = 32'd2097152;

  localparam logic [3:0] OpContinue = 4'h0;
  localparam logic [3:0] OpText     = 4'h1;
  localparam logic [3:0] OpBinary   = 4'h2;
  localparam logic [3:0] OpClose    = 4'h8;
  localparam logic [3:0] OpPing     = 4'h9;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  typedef enum logic [1:0] {
    KindData  = 2'd0,
    KindPing  = 2'd1,
    KindClose = 2'd2,
    KindBig   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       frame_end;
    kind_e      kind;
  } res_t;

  typedef struct packed {
    logic       halted;
    logic [2:0] phase;
  } status_t;

endpackage

// ----- src/wsfd_parser.sv -----
// ----------------------------------------------------------------------------
// wsfd_parser
// Front end: header/length/mask parsing, unmasking and result classification.
// ----------------------------------------------------------------------------
module wsfd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_wdata_i,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  output logic             push_o,
  output wsfd_pkg::res_t   res_o,
  output wsfd_pkg::status_t status_o
);
  import wsfd_pkg::*;

  localparam logic [2:0] PhHdr0    = 3'd0;
  localparam logic [2:0] PhHdr1    = 3'd1;
  localparam logic [2:0] PhExtLen  = 3'd2;
  localparam logic [2:0] PhMask    = 3'd3;
  localparam logic [2:0] PhPayload = 3'd4;

  logic [31:0] max_len_q;
  logic [2:0]  phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic [63:0] len_q, len_d;
  logic [3:0]  len_left_q, len_left_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  key_cnt_q, key_cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [1:0]  pos_q, pos_d;
  logic        halted_q, halted_d;

  logic        len_known;
  logic        begin_pl;
  logic [63:0] len_val;
  logic [7:0]  key_byte;
  logic [7:0]  data;
  logic        last;
  logic        is_data;

  always_comb begin
    unique case (pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign data    = mask_q ? (rx_byte_i ^ key_byte) : rx_byte_i;
  assign last    = (rem_q == 32'd1);
  assign is_data = (opcode_q == OpContinue) || (opcode_q == OpText) ||
                   (opcode_q == OpBinary);

  always_comb begin
    phase_d    = phase_q;
    opcode_d   = opcode_q;
    mask_d     = mask_q;
    len_d      = len_q;
    len_left_d = len_left_q;
    key_d      = key_q;
    key_cnt_d  = key_cnt_q;
    rem_d      = rem_q;
    pos_d      = pos_q;
    halted_d   = halted_q;
    len_known  = 1'b0;
    begin_pl   = 1'b0;
    len_val    = len_q;
    push_o     = 1'b0;
    res_o      = '0;

    if (accept_i && !halted_q) begin
      unique case (phase_q)
        PhHdr0: begin
          opcode_d = rx_byte_i[3:0];
          phase_d  = PhHdr1;
        end
        PhHdr1: begin
          mask_d = rx_byte_i[7];
          len_d  = '0;
          if (rx_byte_i[6:0] == Len16Code || rx_byte_i[6:0] == Len64Code) begin
            len_left_d = (rx_byte_i[6:0] == Len16Code) ? 4'd2 : 4'd8;
            phase_d    = PhExtLen;
          end else begin
            len_val   = {57'd0, rx_byte_i[6:0]};
            len_d     = len_val;
            len_known = 1'b1;
          end
        end
        PhExtLen: begin
          len_val    = {len_q[55:0], rx_byte_i};
          len_d      = len_val;
          len_left_d = len_left_q - 4'd1;
          len_known  = (len_left_q == 4'd1);
        end
        PhMask: begin
          key_d     = {key_q[23:0], rx_byte_i};
          key_cnt_d = key_cnt_q + 2'd1;
          begin_pl  = (key_cnt_q == 2'd3);
        end
        PhPayload: begin
          pos_d = pos_q + 2'd1;
          rem_d = rem_q - 32'd1;
          if (last) begin
            phase_d = PhHdr0;
          end
          if (is_data) begin
            push_o = 1'b1;
            res_o  = '{payload_byte: data, byte_valid: 1'b1, frame_end: last,
                       kind: KindData};
          end else if (opcode_q == OpPing) begin
            push_o = 1'b1;
            res_o  = '{payload_byte: data, byte_valid: 1'b1, frame_end: last,
                       kind: KindPing};
          end else if (opcode_q == OpClose && last) begin
            halted_d = 1'b1;
            push_o   = 1'b1;
            res_o    = '{payload_byte: 8'd0, byte_valid: 1'b0, frame_end: 1'b1,
                         kind: KindClose};
          end
        end
        default: begin
          phase_d = PhHdr0;
        end
      endcase

      if (len_known) begin
        if (len_val > {32'd0, max_len_q}) begin
          halted_d = 1'b1;
          push_o   = 1'b1;
          res_o    = '{payload_byte: 8'd0, byte_valid: 1'b0, frame_end: 1'b1,
                       kind: KindBig};
        end else begin
          rem_d = len_val[31:0];
          if (mask_d) begin
            key_cnt_d = 2'd0;
            phase_d   = PhMask;
          end else begin
            begin_pl = 1'b1;
          end
        end
      end

      if (begin_pl) begin
        pos_d = 2'd0;
        if (rem_d != 32'd0) begin
          phase_d = PhPayload;
        end else begin
          phase_d = PhHdr0;
          if (opcode_q == OpClose) begin
            halted_d = 1'b1;
            push_o   = 1'b1;
            res_o    = '{payload_byte: 8'd0, byte_valid: 1'b0, frame_end: 1'b1,
                         kind: KindClose};
          end else if (opcode_q == OpPing) begin
            push_o = 1'b1;
            res_o  = '{payload_byte: 8'd0, byte_valid: 1'b0, frame_end: 1'b1,
                       kind: KindPing};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q  <= MaxLenReset;
      phase_q    <= PhHdr0;
      opcode_q   <= '0;
      mask_q     <= 1'b0;
      len_q      <= '0;
      len_left_q <= '0;
      key_q      <= '0;
      key_cnt_q  <= '0;
      rem_q      <= '0;
      pos_q      <= '0;
      halted_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      phase_q    <= phase_d;
      opcode_q   <= opcode_d;
      mask_q     <= mask_d;
      len_q      <= len_d;
      len_left_q <= len_left_d;
      key_q      <= key_d;
      key_cnt_q  <= key_cnt_d;
      rem_q      <= rem_d;
      pos_q      <= pos_d;
      halted_q   <= halted_d;
    end
  end

  assign status_o = '{halted: halted_q, phase: phase_q};

endmodule

// ----- src/wsfd_fifo.sv -----
// ----------------------------------------------------------------------------
// wsfd_fifo
// Result queue between the parser and the output channel.
// ----------------------------------------------------------------------------
module wsfd_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  wsfd_pkg::res_t              data_i,
  output logic                        full_o,
  output logic                        valid_o,
  input  logic                        stall_i,
  output wsfd_pkg::res_t              data_o,
  output logic [wsfd_pkg::FifoCw-1:0] count_o
);
  import wsfd_pkg::*;

  res_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCw-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == FifoCw'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = valid_o && !stall_i;
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + FifoCw'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - FifoCw'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FifoAw'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FifoAw'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- src/websocket_frame_deframer_top.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Receive-side WebSocket frame deframer: stream bytes in, payload bytes out.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with rx_byte_i, one byte per transfer.
// Output channel: out_valid_o / out_stall_i with payload_byte_o, byte_valid_o,
// frame_end_o and kind_o, one result per transfer.
// Config: cfg_we_i writes cfg_wdata_i into the max frame length register.
// Header bytes, length bytes and mask bytes give no result; payload bytes of
// data and ping frames give one each; empty pings, close frames and oversize
// lengths give a single marker with frame_end set.
// Throughput: one byte per cycle while the input is not stalled. Each result
// is registered in a 4-entry result queue and can show on the output in the
// cycle after its byte transfers. The input stalls only on a full queue, so
// a stalled receiver lets up to four results collect before input backs up.
// After a close or too-large result the parser halts and drops every byte.
// Reset clears the parser, the queue and restores the 2 MiB length limit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module websocket_frame_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  payload_byte_o,
  output logic        byte_valid_o,
  output logic        frame_end_o,
  output logic [1:0]  kind_o
);
  import wsfd_pkg::*;

  logic              accept;
  logic              push;
  logic              full;
  res_t              push_res;
  res_t              head;
  status_t           status;
  logic [FifoCw-1:0] fifo_cnt;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  wsfd_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .push_o     (push),
    .res_o      (push_res),
    .status_o   (status)
  );

  wsfd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_res),
    .full_o (full),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (head),
    .count_o(fifo_cnt)
  );

  assign payload_byte_o = head.payload_byte;
  assign byte_valid_o   = head.byte_valid;
  assign frame_end_o    = head.frame_end;
  assign kind_o         = head.kind;

  `WSFD_ASSERT(a_cnt_bound, fifo_cnt <= FifoCw'(FifoDepth))
  `WSFD_ASSERT_IMPL(a_marker_zero, out_valid_o && !byte_valid_o,
                    payload_byte_o == 8'd0 && frame_end_o)
  `WSFD_ASSERT_IMPL(a_err_marker, out_valid_o && (kind_o == KindClose || kind_o == KindBig),
                    !byte_valid_o && frame_end_o)
  `WSFD_ASSERT_NEXT(a_err_halts, push && (push_res.kind == KindClose || push_res.kind == KindBig),
                    status.halted)
  `WSFD_ASSERT_IMPL(a_halt_quiet, status.halted, !push)

endmodule

// ----- sim/deframe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframe_checker
// Watches both channels of the deframer. Every accepted stream byte is run
// through a local frame parser that predicts the result it causes. Results
// are queued, and each output transfer is compared field by field, in order.
// ----------------------------------------------------------------------------
module deframe_checker
  import wsfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        byte_valid_i,
  input  logic        frame_end_i,
  input  logic [1:0]  kind_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o
);

  typedef enum logic [2:0] {PhHdr0, PhHdr1, PhExtLen, PhKey, PhPayload} phase_e;

  phase_e      phase;
  logic [3:0]  opcode;
  logic        masked;
  logic [63:0] len_acc;
  logic [3:0]  ext_left;
  logic [31:0] key;
  logic [2:0]  key_seen;
  logic [31:0] remaining;
  logic [1:0]  pos;
  logic        halted;
  logic [31:0] max_len;

  res_t deframed_q [$];
  res_t want;
  bit   hit;

  // header and key complete
  task automatic open_payload(output bit emit, output res_t r);
    r = '0;
    emit = 1'b0;
    pos = 2'd0;
    if (remaining != 32'd0) begin
      phase = PhPayload;
    end else begin
      phase = PhHdr0;
      if (opcode == OpClose) begin
        halted = 1'b1;
        emit = 1'b1;
        r.frame_end = 1'b1;
        r.kind = KindClose;
      end else if (opcode == OpPing) begin
        emit = 1'b1;
        r.frame_end = 1'b1;
        r.kind = KindPing;
      end
    end
  endtask

  // limit check comes before any opcode handling
  task automatic length_done(output bit emit, output res_t r);
    r = '0;
    emit = 1'b0;
    if (len_acc > {32'd0, max_len}) begin
      halted = 1'b1;
      emit = 1'b1;
      r.frame_end = 1'b1;
      r.kind = KindBig;
    end else begin
      remaining = len_acc[31:0];
      key = '0;
      if (masked) begin
        key_seen = 3'd0;
        phase = PhKey;
      end else begin
        open_payload(emit, r);
      end
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, output bit emit, output res_t r);
    int         shift;
    logic [7:0] data;
    bit         last;
    r = '0;
    emit = 1'b0;
    if (!halted) begin
      case (phase)
        PhHdr0: begin
          opcode = b[3:0];
          phase = PhHdr1;
        end
        PhHdr1: begin
          masked = b[7];
          len_acc = '0;
          if (b[6:0] == Len16Code || b[6:0] == Len64Code) begin
            ext_left = (b[6:0] == Len16Code) ? 4'd2 : 4'd8;
            phase = PhExtLen;
          end else begin
            len_acc = {57'd0, b[6:0]};
            length_done(emit, r);
          end
        end
        PhExtLen: begin
          len_acc = {len_acc[55:0], b};
          ext_left = ext_left - 4'd1;
          if (ext_left == 4'd0) length_done(emit, r);
        end
        PhKey: begin
          key = {key[23:0], b};
          key_seen = key_seen + 3'd1;
          if (key_seen == 3'd4) open_payload(emit, r);
        end
        default: begin
          shift = (3 - int'(pos)) * 8;
          data = masked ? (b ^ key[shift +: 8]) : b;
          pos = pos + 2'd1;
          remaining = remaining - 32'd1;
          last = (remaining == 32'd0);
          if (last) phase = PhHdr0;
          if (opcode == OpContinue || opcode == OpText || opcode == OpBinary ||
              opcode == OpPing) begin
            emit = 1'b1;
            r.payload_byte = data;
            r.byte_valid = 1'b1;
            r.frame_end = last;
            r.kind = (opcode == OpPing) ? KindPing : KindData;
          end else if (opcode == OpClose && last) begin
            halted = 1'b1;
            emit = 1'b1;
            r.frame_end = 1'b1;
            r.kind = KindClose;
          end
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase = PhHdr0;
      opcode = '0;
      masked = 1'b0;
      len_acc = '0;
      ext_left = '0;
      key = '0;
      key_seen = '0;
      remaining = '0;
      pos = '0;
      halted = 1'b0;
      max_len = MaxLenReset;
      deframed_q.delete();
      errors_o = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_we_i) max_len = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        deframe_byte(rx_byte_i, hit, want);
        if (hit) deframed_q.insert(deframed_q.size(), want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (deframed_q.size() == 0) begin
          errors_o++;
          $display("%0t: result transfer, expected none, actual byte %0d valid %0b end %0b kind %0d",
                   $time, payload_byte_i, byte_valid_i, frame_end_i, kind_i);
        end else begin
          want = deframed_q.pop_front();
          check_field("payload_byte", want.payload_byte, payload_byte_i);
          check_field("byte_valid", want.byte_valid, byte_valid_i);
          check_field("frame_end", want.frame_end, frame_end_i);
          check_field("kind", want.kind, kind_i);
          checked_o++;
        end
      end
      pending_o = deframed_q.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Frame stream stimulus for the WebSocket deframer. A directed set of frames
// is followed by random frames under several length limits, with random
// idling on both channels, a quiet stretch and one long receiver hold-off.
// The run ends on a fatal frame, then drops trailing bytes.
// ----------------------------------------------------------------------------
module testbench;
  import wsfd_pkg::*;

  localparam int         IdlePct    = 37;
  localparam int         HoldCycles = 300;
  localparam logic [3:0] OpReserved = 4'hF;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  payload_byte_o;
  logic        byte_valid_o;
  logic        frame_end_o;
  logic [1:0]  kind_o;

  int          errors;
  int          pending;
  int          checked;
  bit          quiet;
  bit          hold_go;
  bit          hold_done = 1'b0;
  logic [31:0] cur_max;
  int          bytes_sent;
  int          frames_sent;
  string       ending;

  websocket_frame_deframer_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .payload_byte_o (payload_byte_o),
    .byte_valid_o   (byte_valid_o),
    .frame_end_o    (frame_end_o),
    .kind_o         (kind_o)
  );

  deframe_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .payload_byte_i (payload_byte_o),
    .byte_valid_i   (byte_valid_o),
    .frame_end_i    (frame_end_o),
    .kind_i         (kind_o),
    .errors_o       (errors),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  // receiver: random stall, one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end
      out_stall_i <= (!quiet && $urandom_range(99) < IdlePct);
    end
  end

  // entered and left at a falling edge; valid stays high for a following transfer
  task automatic push_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // enc: 0 shortest length code, 1 forced 16-bit, 2 forced 64-bit; fill < 0 random
  task automatic send_frame(input logic [3:0] op, input bit masked, input logic [63:0] len,
                            input int enc, input int fill);
    logic [6:0]      code;
    logic [31:0]     key;
    int              i;
    longint unsigned k;
    key = $urandom;
    if (enc == 2 || len > 64'd65535) code = Len64Code;
    else if (enc == 1 || len > 64'd125) code = Len16Code;
    else code = len[6:0];
    push_byte({4'($urandom), op});
    push_byte({masked, code});
    if (code == Len16Code) begin
      push_byte(len[15:8]);
      push_byte(len[7:0]);
    end else if (code == Len64Code) begin
      for (i = 7; i >= 0; i--) push_byte(len[8*i +: 8]);
    end
    frames_sent++;
    if (len <= {32'd0, cur_max}) begin
      if (masked) for (i = 3; i >= 0; i--) push_byte(key[8*i +: 8]);
      for (k = 0; k < len; k++) push_byte((fill < 0) ? 8'($urandom) : 8'(fill));
    end
  endtask

  task automatic random_frame();
    int          pick;
    int          enc;
    logic [3:0]  op;
    logic [63:0] len;
    pick = $urandom_range(99);
    if (pick < 60) begin
      op = 4'($urandom_range(2));
    end else if (pick < 75) begin
      op = OpPing;
    end else begin
      op = 4'($urandom_range(13, 3));
      if (op >= OpClose) op = op + 4'd2;
    end
    pick = $urandom_range(99);
    if (pick < 70) len = 64'($urandom_range(8));
    else if (pick < 95) len = 64'($urandom_range(40, 9));
    else len = 64'($urandom_range(300, 100));
    if (len > {32'd0, cur_max}) len = {32'd0, cur_max};
    pick = $urandom_range(99);
    enc = (pick < 80) ? 0 : (pick < 90) ? 1 : 2;
    send_frame(op, 1'($urandom), len, enc, -1);
  endtask

  task automatic run_random(input int n);
    int stop;
    stop = bytes_sent + n;
    while (bytes_sent < stop) random_frame();
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_max(input logic [31:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    cur_max = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int          pick;
    logic [63:0] len;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    rx_byte_i = '0;
    quiet = 1'b0;
    hold_go = 1'b0;
    cur_max = MaxLenReset;
    bytes_sent = 0;
    frames_sent = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_frame(OpText, 1'b0, 0, 0, -1);
    send_frame(OpBinary, 1'b0, 1, 0, 8'hFF);
    send_frame(OpContinue, 1'b1, 1, 0, 8'h00);
    send_frame(OpPing, 1'b0, 0, 0, -1);
    send_frame(OpPing, 1'b1, 0, 0, -1);
    send_frame(OpPing, 1'b1, 2, 0, -1);
    send_frame(OpReserved, 1'b0, 2, 0, -1);
    send_frame(OpText, 1'b0, 3, 1, -1);
    send_frame(OpBinary, 1'b1, 5, 2, -1);

    run_random(150);
    quiet = 1'b1;
    run_random(100);
    quiet = 1'b0;
    hold_go = 1'b1;
    while (!hold_done) random_frame();

    settle();
    write_max(32'd0);
    run_random(80);
    settle();
    write_max(32'hFFFF_FFFF);
    run_random(140);
    settle();
    write_max($urandom_range(40, 1));
    run_random(100);
    settle();
    write_max($urandom);
    run_random(80);
    settle();

    pick = $urandom_range(3);
    case (pick)
      0: begin
        ending = "an empty close frame";
        send_frame(OpClose, 1'($urandom), 0, $urandom_range(2), -1);
      end
      1: begin
        ending = "a close frame with payload";
        len = 64'($urandom_range(20, 1));
        if (len > {32'd0, cur_max}) len = {32'd0, cur_max};
        send_frame(OpClose, 1'($urandom), len, $urandom_range(2), -1);
      end
      2: begin
        ending = "a length just over the limit";
        write_max($urandom_range(200));
        len = {32'd0, cur_max} + 64'd1 + 64'($urandom_range(20));
        send_frame(4'($urandom), 1'($urandom), len, $urandom_range(2), -1);
      end
      default: begin
        ending = "a 64-bit length beyond 32 bits";
        len = {$urandom | 32'd1, $urandom};
        send_frame(4'($urandom), 1'($urandom), len, 2, -1);
      end
    endcase
    // halted: these are dropped
    repeat (24) push_byte(8'($urandom));
    settle();

    $display("covered %0d stream bytes in %0d frames, %0d results compared",
             bytes_sent, frames_sent, checked);
    $display("limits: reset, zero, all ones, small, random; halted by %s", ending);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
